FILE: rtl/rrsched_pkg.sv
package rrsched_pkg;

    localparam int THREAD_SLOTS_DEF  = 16;
    localparam int PERIOD_W          = 16;
    localparam logic [PERIOD_W-1:0] SWITCH_PERIOD_RST = 16'd10;

    localparam int MODE_W   = 2;
    localparam int TID_W    = 4;
    localparam int OWNER_W  = 8;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 3;
    localparam int SLOTNO_W = 4;
    localparam int TOTAL_W  = 5;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_CREATE = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_SWEEP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SLOT_STOPPED  = 2'd0,
        SLOT_RUNNING  = 2'd1,
        SLOT_STOPPING = 2'd2,
        SLOT_ZOMBIE   = 2'd3
    } slot_state_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK               = 3'd0,
        STAT_TABLE_FULL       = 3'd1,
        STAT_NO_FREE_SLOT     = 3'd2,
        STAT_ALREADY_STOPPED  = 3'd3,
        STAT_ALREADY_STOPPING = 3'd4,
        STAT_ZOMBIE_REFUSED   = 3'd5
    } status_t;

    // input item as packed on s_tdata, lowest field last
    typedef struct packed {
        logic               pad;
        logic               blocked;
        logic               free_zombies;
        logic               force_free;
        logic [PRIO_W-1:0]  priority_req;
        logic [OWNER_W-1:0] owner_pid;
        logic [TID_W-1:0]   target_slot;
    } in_item_t;

    // result item as packed on m_tdata, lowest field last
    typedef struct packed {
        logic                pad;
        logic [TOTAL_W-1:0]  live_threads;
        logic [SLOTNO_W-1:0] running_thread;
        logic                yielded;
        logic                switched;
        logic [TOTAL_W-1:0]  zombie_total;
        logic [SLOTNO_W-1:0] new_thread;
        status_t             status;
    } out_item_t;

    typedef struct packed {
        logic init_wr;
        logic capture;
        logic setup;
        logic scan;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/rrsched_ram.sv
module rrsched_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rrsched_ctrl.sv
module rrsched_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  rrsched_pkg::dp_status_t status,
    output rrsched_pkg::ctrl_cmd_t  cmd
);
    import rrsched_pkg::*;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SETUP = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } fsm_t;

    fsm_t state_reg;
    fsm_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (status.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = status.need_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.load_out = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/rrsched_dp.sv
module rrsched_dp #(
    parameter int THREAD_SLOTS = rrsched_pkg::THREAD_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rrsched_pkg::PERIOD_W-1:0]    cfg_wr_data,
    input  logic [rrsched_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [rrsched_pkg::MODE_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rrsched_pkg::M_TDATA_W-1:0]   m_tdata,
    input  rrsched_pkg::ctrl_cmd_t              cmd,
    output rrsched_pkg::dp_status_t             status
);
    import rrsched_pkg::*;

    localparam int SLOT_W  = $clog2(THREAD_SLOTS);
    localparam int CNT_W   = $clog2(THREAD_SLOTS + 1);
    localparam int STATE_W = $bits(slot_state_t);

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] a);
        logic [SLOT_W-1:0] r;
        r = (a == SLOT_W'(THREAD_SLOTS - 1)) ? '0 : a + 1'b1;
        return r;
    endfunction

    in_item_t s_item;

    // latched command
    mode_t             mode_reg,    mode_next;
    logic [TID_W-1:0]  tid_reg,     tid_next;
    logic              force_reg,   force_next;
    logic              zfree_reg,   zfree_next;
    logic              blocked_reg, blocked_next;

    // scheduler state
    logic [PERIOD_W-1:0] period_reg,  period_next;
    logic [PERIOD_W-1:0] tick_reg,    tick_next;
    logic [SLOT_W-1:0]   current_reg, current_next;
    logic [CNT_W-1:0]    count_reg,   count_next;

    // slot walk
    logic [SLOT_W-1:0] scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]  left_reg,      left_next;
    logic              pend_reg,      pend_next;
    logic [SLOT_W-1:0] pend_addr_reg, pend_addr_next;
    logic              found_reg,     found_next;

    // result under construction
    status_t           res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_new_reg,    res_new_next;
    logic [CNT_W-1:0]  res_zomb_reg,   res_zomb_next;
    logic              res_sw_reg,     res_sw_next;
    logic              res_y_reg,      res_y_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg,  m_data_next;

    // state table port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    slot_state_t       ram_wdata;
    logic              ram_re;
    logic [STATE_W-1:0] ram_rdata;
    slot_state_t       rd_state;

    logic [PERIOD_W:0] tick_inc;
    logic              tick_active;
    logic              tick_switch;
    logic              create_full;
    logic              stop_in_range;
    logic [SLOT_W-1:0] stop_addr;
    logic              issue;
    logic              eval;
    logic              need_scan;
    out_item_t         out_item;

    assign s_item   = in_item_t'(s_tdata);
    assign rd_state = slot_state_t'(ram_rdata);

    assign tick_inc      = {1'b0, tick_reg} + 1'b1;
    assign tick_active   = (mode_reg == MODE_TICK) && !blocked_reg && (count_reg != '0);
    assign tick_switch   = tick_active && (tick_inc > {1'b0, period_reg});
    assign create_full   = count_reg >= CNT_W'(THREAD_SLOTS);
    assign stop_in_range = (tid_reg == '0) || (32'(tid_reg) < THREAD_SLOTS);
    assign stop_addr     = (tid_reg == '0) ? current_reg : SLOT_W'(tid_reg);

    assign issue = cmd.scan && (left_reg != '0) && !found_reg;
    assign eval  = cmd.scan && pend_reg && !found_reg;

    always_comb begin
        unique case (mode_reg)
            MODE_TICK:   need_scan = tick_switch;
            MODE_CREATE: need_scan = !create_full;
            MODE_STOP:   need_scan = stop_in_range;
            MODE_SWEEP:  need_scan = 1'b1;
            default:     need_scan = 1'b0;
        endcase
    end

    assign status.need_scan = need_scan;
    assign status.init_last = scan_addr_reg == SLOT_W'(THREAD_SLOTS - 1);
    assign status.scan_done = ((left_reg == '0) && !pend_reg) || found_reg;
    assign status.out_free  = !m_valid_reg || m_tready;

    always_comb begin
        out_item                = '0;
        out_item.status         = res_status_reg;
        out_item.new_thread     = SLOTNO_W'(res_new_reg);
        out_item.zombie_total   = TOTAL_W'(res_zomb_reg);
        out_item.switched       = res_sw_reg;
        out_item.yielded        = res_y_reg;
        out_item.running_thread = SLOTNO_W'(current_reg);
        out_item.live_threads   = TOTAL_W'(count_reg);
    end

    always_comb begin
        mode_next       = mode_reg;
        tid_next        = tid_reg;
        force_next      = force_reg;
        zfree_next      = zfree_reg;
        blocked_next    = blocked_reg;
        period_next     = cfg_wr_en ? cfg_wr_data : period_reg;
        tick_next       = tick_reg;
        current_next    = current_reg;
        count_next      = count_reg;
        scan_addr_next  = scan_addr_reg;
        left_next       = left_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_new_next    = res_new_reg;
        res_zomb_next   = res_zomb_reg;
        res_sw_next     = res_sw_reg;
        res_y_next      = res_y_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = SLOT_STOPPED;
        ram_re          = 1'b0;

        // clearing pass after reset: slot 0 running, the rest stopped
        if (cmd.init_wr) begin
            ram_we         = 1'b1;
            ram_waddr      = scan_addr_reg;
            ram_wdata      = (scan_addr_reg == '0) ? SLOT_RUNNING : SLOT_STOPPED;
            scan_addr_next = wrap_inc(scan_addr_reg);
        end

        if (cmd.capture) begin
            mode_next    = mode_t'(s_tuser);
            tid_next     = s_item.target_slot;
            force_next   = s_item.force_free;
            zfree_next   = s_item.free_zombies;
            blocked_next = s_item.blocked;
        end

        if (cmd.setup) begin
            res_status_next = STAT_OK;
            res_new_next    = '0;
            res_zomb_next   = '0;
            res_sw_next     = 1'b0;
            res_y_next      = 1'b0;
            found_next      = 1'b0;
            pend_next       = 1'b0;
            left_next       = '0;
            unique case (mode_reg)
                MODE_TICK: begin
                    if (tick_switch) begin
                        // slot 0 unless the walk finds a live slot
                        tick_next      = '0;
                        current_next   = '0;
                        res_sw_next    = 1'b1;
                        scan_addr_next = wrap_inc(current_reg);
                        left_next      = CNT_W'(THREAD_SLOTS);
                    end else if (tick_active) begin
                        tick_next  = tick_inc[PERIOD_W-1:0];
                        res_y_next = tick_inc == {1'b0, (period_reg >> 1)};
                    end
                end
                MODE_CREATE: begin
                    if (create_full) begin
                        res_status_next = STAT_TABLE_FULL;
                    end else begin
                        res_status_next = STAT_NO_FREE_SLOT;
                        scan_addr_next  = SLOT_W'(1);
                        left_next       = CNT_W'(THREAD_SLOTS - 1);
                    end
                end
                MODE_STOP: begin
                    if (!stop_in_range) begin
                        res_status_next = STAT_ALREADY_STOPPED;
                    end else begin
                        scan_addr_next = stop_addr;
                        left_next      = CNT_W'(1);
                    end
                end
                MODE_SWEEP: begin
                    scan_addr_next = '0;
                    left_next      = CNT_W'(THREAD_SLOTS);
                end
                default: begin
                    left_next = '0;
                end
            endcase
        end

        if (cmd.scan) begin
            // read one slot per cycle, data is handled the cycle after
            pend_next = issue;
            if (issue) begin
                ram_re         = 1'b1;
                pend_addr_next = scan_addr_reg;
                scan_addr_next = wrap_inc(scan_addr_reg);
                left_next      = left_reg - 1'b1;
            end
        end

        if (eval) begin
            unique case (mode_reg)
                MODE_TICK: begin
                    if (rd_state == SLOT_RUNNING || rd_state == SLOT_STOPPING) begin
                        found_next   = 1'b1;
                        current_next = pend_addr_reg;
                    end
                end
                MODE_CREATE: begin
                    if (rd_state == SLOT_STOPPED) begin
                        found_next      = 1'b1;
                        ram_we          = 1'b1;
                        ram_wdata       = SLOT_RUNNING;
                        count_next      = count_reg + 1'b1;
                        res_new_next    = pend_addr_reg;
                        res_status_next = STAT_OK;
                    end
                end
                MODE_STOP: begin
                    unique case (rd_state)
                        SLOT_ZOMBIE: begin
                            res_status_next = STAT_ZOMBIE_REFUSED;
                        end
                        SLOT_STOPPED: begin
                            res_status_next = STAT_ALREADY_STOPPED;
                            ram_we          = force_reg;
                        end
                        SLOT_STOPPING: begin
                            res_status_next = STAT_ALREADY_STOPPING;
                            ram_we          = force_reg;
                        end
                        SLOT_RUNNING: begin
                            ram_we    = 1'b1;
                            ram_wdata = force_reg ? SLOT_STOPPED : SLOT_STOPPING;
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default: begin
                            res_status_next = STAT_ZOMBIE_REFUSED;
                        end
                    endcase
                end
                MODE_SWEEP: begin
                    if (rd_state == SLOT_STOPPING) begin
                        ram_we    = 1'b1;
                        ram_wdata = SLOT_ZOMBIE;
                    end else if (rd_state == SLOT_ZOMBIE) begin
                        res_zomb_next = res_zomb_reg + 1'b1;
                        ram_we        = zfree_reg;
                    end
                end
                default: begin
                    found_next = found_reg;
                end
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = M_TDATA_W'(out_item);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= SWITCH_PERIOD_RST;
            tick_reg      <= '0;
            current_reg   <= '0;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            period_reg    <= period_next;
            tick_reg      <= tick_next;
            current_reg   <= current_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        tid_reg        <= tid_next;
        force_reg      <= force_next;
        zfree_reg      <= zfree_next;
        blocked_reg    <= blocked_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_new_reg    <= res_new_next;
        res_zomb_reg   <= res_zomb_next;
        res_sw_reg     <= res_sw_next;
        res_y_reg      <= res_y_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    rrsched_ram #(
        .WIDTH (STATE_W),
        .DEPTH (THREAD_SLOTS)
    ) u_state_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (STATE_W'(ram_wdata)),
        .re    (ram_re),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/thread_table_round_robin_scheduler.sv
// Round-robin thread scheduler over a table of THREAD_SLOTS slots, one command
// per input item (tick, create, stop, sweep) and exactly one result item per
// command. Slot states live in a single-port-write, registered-read RAM that is
// walked one slot per cycle. After reset the block runs a clearing pass over
// all THREAD_SLOTS slots with s_tready low. A command that needs no table
// access (tick without switch, create on a full table, stop beyond the table)
// goes from setup straight to the result; one that walks the table reads
// slots in turn: a stop walks one slot, a sweep all THREAD_SLOTS, a create or
// a switching tick stops at the first hit. Items are taken one at a time; a
// new item is taken while the previous result still waits on m_tready. A slot
// is free for a create exactly when it is stopped. The owner and priority given
// with a create are not kept, since no result ever depends on them.
// switch_period may only be written while no command is in progress.
module thread_table_round_robin_scheduler #(
    parameter int THREAD_SLOTS = rrsched_pkg::THREAD_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rrsched_pkg::PERIOD_W-1:0]  cfg_wr_data,  // switch_period
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // target_slot[3:0], owner_pid[11:4], priority_req[19:12], force_free[20],
    // free_zombies[21], blocked[22], zero[23]
    input  logic [rrsched_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rrsched_pkg::MODE_W-1:0]    s_tuser,      // mode[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[2:0], new_thread[6:3], zombie_total[11:7], switched[12],
    // yielded[13], running_thread[17:14], live_threads[22:18], zero[23]
    output logic [rrsched_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrsched_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    rrsched_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrsched_dp #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
